// ===== rtl/mqr_pkg.sv =====
// ----------------------------------------------------------------------------
// mqr_pkg
// Shared types and constants of the multi-queue thread run queues block.
// ----------------------------------------------------------------------------
package mqr_pkg;

    localparam int NUM_QUEUES_DEF  = 8;
    localparam int NUM_THREADS_DEF = 64;

    localparam int KIND_W = 2;
    localparam int QID_W  = 3;
    localparam int TID_W  = 6;
    localparam int ST_W   = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT   = 2'd0,
        KIND_REMOVE   = 2'd1,
        KIND_NEXT     = 2'd2,
        KIND_MOVE_ALL = 2'd3
    } t_kind;

    typedef enum logic [ST_W-1:0] {
        ST_OK         = 2'd0,
        ST_EMPTY      = 2'd1,
        ST_NOT_MEMBER = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DISPATCH, S_INS_CHK, S_REM_CHK, S_UL_HEAD, S_UL_WALK,
        S_REM_FIN, S_NXT, S_APP1, S_APP2, S_MV_WR, S_MV_NX, S_MV_LINK, S_DONE
    } t_state;

    typedef enum logic [4:0] {
        CMD_NONE, CMD_CLEAR, CMD_LOAD, CMD_RD_TH, CMD_ST_EMPTY, CMD_ST_NOT_MEMBER,
        CMD_NXT_RD, CMD_MV_START, CMD_LATCH, CMD_UL_HEAD, CMD_UL_FIRST, CMD_UL_STEP,
        CMD_UL_SPLICE, CMD_REM_FIN, CMD_NXT_POP, CMD_APP1, CMD_APP2, CMD_MV_WR,
        CMD_MV_STEP, CMD_MV_LINK, CMD_DONE
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  qok;
        logic  tok;
        logic  hv_q;
        logic  move_ok;
        logic  single_q;
        logic  mem_valid;
        logic  mem_eq_q;
        logic  head_m_eq_t;
        logic  link_nil;
        logic  link_eq_t;
        logic  clr_last;
        logic  out_free;
    } t_flags;

endpackage

// ===== rtl/mqr_in_if.sv =====
// ----------------------------------------------------------------------------
// mqr_in_if
// Operation channel: valid/ready handshake with the operation fields.
// ----------------------------------------------------------------------------
interface mqr_in_if import mqr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [QID_W-1:0]  queue_id;
    logic [TID_W-1:0]  thread_id;
    logic [QID_W-1:0]  source_queue;

    modport source (output valid, kind, queue_id, thread_id, source_queue, input ready);
    modport sink   (input valid, kind, queue_id, thread_id, source_queue, output ready);
endinterface

// ===== rtl/mqr_out_if.sv =====
// ----------------------------------------------------------------------------
// mqr_out_if
// Result channel: valid/ready handshake with the result fields.
// ----------------------------------------------------------------------------
interface mqr_out_if import mqr_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [TID_W-1:0] picked_thread;
    logic [ST_W-1:0]  status;
    logic             now_empty;

    modport source (output valid, picked_thread, status, now_empty, input ready);
    modport sink   (input valid, picked_thread, status, now_empty, output ready);
endinterface

// ===== rtl/mqr_ram.sv =====
// ----------------------------------------------------------------------------
// mqr_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module mqr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/mqr_ctrl.sv =====
// ----------------------------------------------------------------------------
// mqr_ctrl
// Controller: sequences the clearing sweep and each operation's micro-steps.
// ----------------------------------------------------------------------------
module mqr_ctrl import mqr_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    input  t_flags i_flags,
    output logic   o_in_ready,
    output t_cmd   o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = CMD_NONE;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd = CMD_CLEAR;
                if (i_flags.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd   = CMD_LOAD;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_flags.kind)
                    KIND_INSERT: begin
                        if (i_flags.qok && i_flags.tok) begin
                            o_cmd   = CMD_RD_TH;
                            n_state = S_INS_CHK;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                    KIND_REMOVE: begin
                        if (i_flags.qok && i_flags.tok) begin
                            o_cmd   = CMD_RD_TH;
                            n_state = S_REM_CHK;
                        end else begin
                            o_cmd   = CMD_ST_NOT_MEMBER;
                            n_state = S_DONE;
                        end
                    end
                    KIND_NEXT: begin
                        if (i_flags.qok && i_flags.hv_q) begin
                            o_cmd   = CMD_NXT_RD;
                            n_state = S_NXT;
                        end else begin
                            o_cmd   = CMD_ST_EMPTY;
                            n_state = S_DONE;
                        end
                    end
                    default: begin
                        if (i_flags.move_ok) begin
                            o_cmd   = CMD_MV_START;
                            n_state = S_MV_WR;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                endcase
            end
            S_INS_CHK: begin
                o_cmd   = CMD_LATCH;
                n_state = i_flags.mem_valid ? S_UL_HEAD : S_APP1;
            end
            S_REM_CHK: begin
                if (i_flags.mem_valid && i_flags.mem_eq_q) begin
                    o_cmd   = CMD_LATCH;
                    n_state = S_UL_HEAD;
                end else begin
                    o_cmd   = CMD_ST_NOT_MEMBER;
                    n_state = S_DONE;
                end
            end
            S_UL_HEAD: begin
                if (i_flags.head_m_eq_t) begin
                    o_cmd   = CMD_UL_HEAD;
                    n_state = (i_flags.kind == KIND_REMOVE) ? S_REM_FIN : S_APP1;
                end else begin
                    o_cmd   = CMD_UL_FIRST;
                    n_state = S_UL_WALK;
                end
            end
            S_UL_WALK: begin
                // walk the list until the predecessor of the thread turns up or the list ends
                if (i_flags.link_nil) begin
                    n_state = (i_flags.kind == KIND_REMOVE) ? S_REM_FIN : S_APP1;
                end else if (i_flags.link_eq_t) begin
                    o_cmd   = CMD_UL_SPLICE;
                    n_state = (i_flags.kind == KIND_REMOVE) ? S_REM_FIN : S_APP1;
                end else begin
                    o_cmd = CMD_UL_STEP;
                end
            end
            S_REM_FIN: begin
                o_cmd   = CMD_REM_FIN;
                n_state = S_DONE;
            end
            S_NXT: begin
                if (i_flags.single_q) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd   = CMD_NXT_POP;
                    n_state = S_APP1;
                end
            end
            S_APP1: begin
                o_cmd   = CMD_APP1;
                n_state = S_APP2;
            end
            S_APP2: begin
                o_cmd   = CMD_APP2;
                n_state = S_DONE;
            end
            S_MV_WR: begin
                o_cmd   = CMD_MV_WR;
                n_state = S_MV_NX;
            end
            S_MV_NX: begin
                if (i_flags.link_nil) begin
                    n_state = S_MV_LINK;
                end else begin
                    o_cmd   = CMD_MV_STEP;
                    n_state = S_MV_WR;
                end
            end
            S_MV_LINK: begin
                o_cmd   = CMD_MV_LINK;
                n_state = S_DONE;
            end
            S_DONE: begin
                // hold until the result register is free
                if (i_flags.out_free) begin
                    o_cmd   = CMD_DONE;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule

// ===== rtl/mqr_dpath.sv =====
// ----------------------------------------------------------------------------
// mqr_dpath
// Datapath: queue head/tail registers, link and membership RAMs, result
// register.
// ----------------------------------------------------------------------------
module mqr_dpath import mqr_pkg::*; #(
    parameter int NUM_QUEUES  = NUM_QUEUES_DEF,
    parameter int NUM_THREADS = NUM_THREADS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic [KIND_W-1:0] i_kind,
    input  logic [QID_W-1:0]  i_queue_id,
    input  logic [TID_W-1:0]  i_thread_id,
    input  logic [QID_W-1:0]  i_source_queue,
    input  logic              i_out_ready,
    output t_flags            o_flags,
    output logic              o_out_valid,
    output logic [TID_W-1:0]  o_picked_thread,
    output logic [ST_W-1:0]   o_status,
    output logic              o_now_empty
);
    localparam int QIW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int TIW = $clog2(NUM_THREADS);

    // link and membership words carry a nil flag in the top bit
    localparam logic [TIW:0] LINK_NIL = {1'b1, {TIW{1'b0}}};
    localparam logic [QIW:0] MEM_NIL  = {1'b1, {QIW{1'b0}}};

    t_kind            r_kind;
    logic [QID_W-1:0] r_q;
    logic [QID_W-1:0] r_src;
    logic             r_tok;
    logic [TIW-1:0]   r_t;
    logic [TIW-1:0]   r_p;
    logic [QIW-1:0]   r_m;
    logic [TIW:0]     r_nxt;
    logic [TIW-1:0]   r_clr;
    t_status          r_status;

    logic [TIW-1:0]    r_head [NUM_QUEUES];
    logic [TIW-1:0]    r_tail [NUM_QUEUES];
    logic [NUM_QUEUES-1:0] r_hv;

    logic             r_ovalid;
    logic [TID_W-1:0] r_opick;
    t_status          r_ostat;
    logic             r_oempty;

    logic           link_we, mem_we;
    logic [TIW-1:0] link_wa, link_ra, mem_wa, mem_ra;
    logic [TIW:0]   link_wd, link_rd;
    logic [QIW:0]   mem_wd, mem_rd;

    logic           qok, srcok;
    logic [QIW-1:0] q_idx, src_idx;

    assign qok     = 32'(r_q) < NUM_QUEUES;
    assign srcok   = 32'(r_src) < NUM_QUEUES;
    assign q_idx   = QIW'(r_q);
    assign src_idx = QIW'(r_src);

    always_comb begin
        o_flags.kind        = r_kind;
        o_flags.qok         = qok;
        o_flags.tok         = r_tok;
        o_flags.hv_q        = r_hv[q_idx];
        o_flags.move_ok     = qok && srcok && (r_src != r_q) && r_hv[src_idx];
        o_flags.single_q    = r_head[q_idx] == r_tail[q_idx];
        o_flags.mem_valid   = !mem_rd[QIW];
        o_flags.mem_eq_q    = mem_rd[QIW-1:0] == q_idx;
        o_flags.head_m_eq_t = r_head[r_m] == r_t;
        o_flags.link_nil    = link_rd[TIW];
        o_flags.link_eq_t   = link_rd[TIW-1:0] == r_t;
        o_flags.clr_last    = r_clr == TIW'(NUM_THREADS - 1);
        o_flags.out_free    = !r_ovalid || i_out_ready;
    end

    // operation registers
    always_ff @(posedge i_clk) begin
        case (i_cmd)
            CMD_LOAD: begin
                r_kind   <= t_kind'(i_kind);
                r_q      <= i_queue_id;
                r_src    <= i_source_queue;
                r_tok    <= 32'(i_thread_id) < NUM_THREADS;
                r_t      <= TIW'(i_thread_id);
                r_status <= ST_OK;
            end
            CMD_ST_EMPTY:      r_status <= ST_EMPTY;
            CMD_ST_NOT_MEMBER: r_status <= ST_NOT_MEMBER;
            CMD_NXT_RD:        r_t <= r_head[q_idx];
            CMD_LATCH: begin
                r_m   <= mem_rd[QIW-1:0];
                r_nxt <= link_rd;
            end
            CMD_UL_FIRST:      r_p <= r_head[r_m];
            CMD_UL_STEP:       r_p <= link_rd[TIW-1:0];
            CMD_MV_START:      r_p <= r_head[src_idx];
            CMD_MV_STEP:       r_p <= link_rd[TIW-1:0];
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd == CMD_CLEAR) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    // queue valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv <= '0;
        end else begin
            case (i_cmd)
                CMD_UL_HEAD: begin
                    if (r_nxt[TIW]) begin
                        r_hv[r_m] <= 1'b0;
                    end
                end
                CMD_APP2:    r_hv[q_idx] <= 1'b1;
                CMD_MV_LINK: begin
                    r_hv[q_idx]   <= 1'b1;
                    r_hv[src_idx] <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // head and tail pointers
    always_ff @(posedge i_clk) begin
        case (i_cmd)
            CMD_UL_HEAD: r_head[r_m] <= r_nxt[TIW-1:0];
            CMD_UL_SPLICE: begin
                if (r_tail[r_m] == r_t) begin
                    r_tail[r_m] <= r_p;
                end
            end
            CMD_NXT_POP: r_head[q_idx] <= link_rd[TIW-1:0];
            CMD_APP2: begin
                if (!r_hv[q_idx]) begin
                    r_head[q_idx] <= r_t;
                end
                r_tail[q_idx] <= r_t;
            end
            CMD_MV_LINK: begin
                if (!r_hv[q_idx]) begin
                    r_head[q_idx] <= r_head[src_idx];
                end
                r_tail[q_idx] <= r_tail[src_idx];
            end
            default: ;
        endcase
    end

    // RAM port selection
    always_comb begin
        link_we = 1'b0;
        link_wa = r_t;
        link_wd = LINK_NIL;
        link_ra = r_t;
        mem_we  = 1'b0;
        mem_wa  = r_t;
        mem_wd  = MEM_NIL;
        mem_ra  = r_t;
        case (i_cmd)
            CMD_CLEAR: begin
                link_we = 1'b1;
                link_wa = r_clr;
                mem_we  = 1'b1;
                mem_wa  = r_clr;
            end
            CMD_NXT_RD:   link_ra = r_head[q_idx];
            CMD_UL_FIRST: link_ra = r_head[r_m];
            CMD_UL_STEP:  link_ra = link_rd[TIW-1:0];
            CMD_UL_SPLICE: begin
                link_we = 1'b1;
                link_wa = r_p;
                link_wd = r_nxt;
            end
            CMD_REM_FIN:  mem_we = 1'b1;
            CMD_APP1: begin
                link_we = 1'b1;
                mem_we  = 1'b1;
                mem_wd  = {1'b0, q_idx};
            end
            CMD_APP2: begin
                link_we = r_hv[q_idx];
                link_wa = r_tail[q_idx];
                link_wd = {1'b0, r_t};
            end
            CMD_MV_WR: begin
                mem_we  = 1'b1;
                mem_wa  = r_p;
                mem_wd  = {1'b0, q_idx};
                link_ra = r_p;
            end
            CMD_MV_LINK: begin
                link_we = r_hv[q_idx];
                link_wa = r_tail[q_idx];
                link_wd = {1'b0, r_head[src_idx]};
            end
            default: ;
        endcase
    end

    mqr_ram #(.WIDTH(TIW + 1), .DEPTH(NUM_THREADS)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_wa),
        .i_wdata (link_wd),
        .i_raddr (link_ra),
        .o_rdata (link_rd)
    );

    mqr_ram #(.WIDTH(QIW + 1), .DEPTH(NUM_THREADS)) u_member_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_wa),
        .i_wdata (mem_wd),
        .i_raddr (mem_ra),
        .o_rdata (mem_rd)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd == CMD_DONE) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd == CMD_DONE) begin
            r_opick  <= (r_kind == KIND_NEXT && r_status == ST_OK) ? TID_W'(r_t) : '0;
            r_ostat  <= r_status;
            r_oempty <= !qok || !r_hv[q_idx];
        end
    end

    assign o_out_valid     = r_ovalid;
    assign o_picked_thread = r_opick;
    assign o_status        = r_ostat;
    assign o_now_empty     = r_oempty;
endmodule

// ===== rtl/multi_queue_thread_run_queues.sv =====
// ----------------------------------------------------------------------------
// multi_queue_thread_run_queues
// Linked-list FIFO run queues with insert, remove, round-robin next and
// move-all.
// ----------------------------------------------------------------------------
//  channel | dir | fields                                        | handshake
//  i_op    | in  | kind, queue_id, thread_id, source_queue       | valid/ready
//  o_res   | out | picked_thread, status, now_empty              | valid/ready
//
//  After reset a clearing pass writes every entry of both RAMs, with
//  no operation accepted.
//  One operation at a time: remove and insert of a member walk the list of
//  the thread's queue to unlink it, and move-all walks the source list thread
//  by thread; the single read port of the link RAM sets the pace of each walk.
//  A finished result waits in the output register while the next operation
//  is taken; a stalled output holds the controller in its final step.
// ----------------------------------------------------------------------------
module multi_queue_thread_run_queues import mqr_pkg::*; #(
    parameter int NUM_QUEUES  = NUM_QUEUES_DEF,
    parameter int NUM_THREADS = NUM_THREADS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    mqr_in_if.sink   i_op,
    mqr_out_if.source o_res
);
    t_cmd   cmd;
    t_flags flags;

    mqr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_op.valid),
        .i_flags    (flags),
        .o_in_ready (i_op.ready),
        .o_cmd      (cmd)
    );

    mqr_dpath #(.NUM_QUEUES(NUM_QUEUES), .NUM_THREADS(NUM_THREADS)) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_kind          (i_op.kind),
        .i_queue_id      (i_op.queue_id),
        .i_thread_id     (i_op.thread_id),
        .i_source_queue  (i_op.source_queue),
        .i_out_ready     (o_res.ready),
        .o_flags         (flags),
        .o_out_valid     (o_res.valid),
        .o_picked_thread (o_res.picked_thread),
        .o_status        (o_res.status),
        .o_now_empty     (o_res.now_empty)
    );
endmodule

// ===== rtl/mqr_checker.sv =====
// ----------------------------------------------------------------------------
// mqr_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module mqr_checker import mqr_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             i_ready,
    input logic [TID_W-1:0] i_pick,
    input logic [ST_W-1:0]  i_status,
    input logic             i_empty
);
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> $stable(i_pick) && $stable(i_status) && $stable(i_empty))
        else $error("result changed while stalled");

    a_pick_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_status != ST_OK |-> i_pick == '0)
        else $error("thread picked on a failed operation");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_status == ST_EMPTY |-> i_empty)
        else $error("empty queue reported as not empty");
endmodule

bind multi_queue_thread_run_queues mqr_checker u_mqr_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (o_res.valid),
    .i_ready  (o_res.ready),
    .i_pick   (o_res.picked_thread),
    .i_status (o_res.status),
    .i_empty  (o_res.now_empty)
);

// ===== tb/multi_queue_thread_run_queues_tb.sv =====
// ----------------------------------------------------------------------------
// multi_queue_thread_run_queues_tb
// Self-checking bench for the run-queue block: directed and random
// scheduler operations, a run-queue predictor and an in-order scoreboard.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multi_queue_thread_run_queues_tb;
    import mqr_pkg::*;

    localparam int NQ = NUM_QUEUES_DEF;
    localparam int NT = NUM_THREADS_DEF;

    typedef struct packed {
        logic [TID_W-1:0] picked;
        t_status          status;
        logic             empty;
    } t_res;

    // Run-queue predictor: each queue kept as an ordered list of thread slots
    class sched_scoreboard;
        int      runq[NQ][$];
        t_res    pending[$];
        int      mismatches;
        int      checked;

        function int find_pos(int q, int th);
            foreach (runq[q][i]) if (runq[q][i] == th) return i;
            return -1;
        endfunction

        function int owner(int th);
            for (int q = 0; q < NQ; q++) if (find_pos(q, th) >= 0) return q;
            return -1;
        endfunction

        function void note_op(t_kind kind, int q, int th, int src);
            t_res r;
            int   m;
            int   h;
            r = '0;
            r.status = ST_OK;
            case (kind)
                KIND_INSERT: begin
                    m = owner(th);
                    if (m >= 0) runq[m].delete(find_pos(m, th));
                    runq[q].push_back(th);
                end
                KIND_REMOVE: begin
                    m = find_pos(q, th);
                    if (m >= 0) runq[q].delete(m);
                    else r.status = ST_NOT_MEMBER;
                end
                KIND_NEXT: begin
                    if (runq[q].size() == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        h = runq[q].pop_front();
                        runq[q].push_back(h);
                        r.picked = TID_W'(h);
                    end
                end
                default: begin
                    if (src != q) begin
                        foreach (runq[src][i]) runq[q].push_back(runq[src][i]);
                        runq[src].delete();
                    end
                end
            endcase
            r.empty = (runq[q].size() == 0);
            pending.push_back(r);
        endfunction

        function void check_result(t_res got);
            t_res exp;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
                return;
            end
            exp = pending.pop_front();
            checked++;
            if (got !== exp) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch #%0d: exp picked=%0d st=%0d empty=%0b, ",
                              "got picked=%0d st=%0d empty=%0b"},
                             checked, exp.picked, exp.status, exp.empty,
                             got.picked, got.status, got.empty);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   calm;
    int   op_count[4];

    mqr_in_if  op_ch ();
    mqr_out_if res_ch ();

    sched_scoreboard board;

    multi_queue_thread_run_queues dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (op_ch.sink),
        .o_res   (res_ch.source)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Result side: random stall bursts, sample at the edge
    initial begin
        int gap;
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        wait (i_rst_n);
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 12);
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge i_clk);
            if (res_ch.valid && res_ch.ready)
                board.check_result({res_ch.picked_thread, t_status'(res_ch.status),
                                    res_ch.now_empty});
        end
    end

    task automatic send_op(t_kind kind, int q, int th, int src);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 12);
            op_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        op_ch.valid        <= 1'b1;
        op_ch.kind         <= kind;
        op_ch.queue_id     <= q[QID_W-1:0];
        op_ch.thread_id    <= th[TID_W-1:0];
        op_ch.source_queue <= src[QID_W-1:0];
        do @(posedge i_clk); while (!op_ch.ready);
        board.note_op(kind, q, th, src);
        op_count[kind]++;
    endtask

    task automatic random_op();
        int   r;
        int   q;
        t_kind k;
        r = $urandom_range(0, 99);
        // Keep a narrow thread pool most of the time so queues fill and lists grow
        q = ($urandom_range(0, 3) == 0) ? $urandom_range(0, NQ - 1) : $urandom_range(0, 2);
        if (r < 40)      k = KIND_INSERT;
        else if (r < 60) k = KIND_REMOVE;
        else if (r < 88) k = KIND_NEXT;
        else             k = KIND_MOVE_ALL;
        send_op(k, q,
                ($urandom_range(0, 2) == 0) ? $urandom_range(0, NT - 1) : $urandom_range(0, 15),
                ($urandom_range(0, 3) == 0) ? $urandom_range(0, NQ - 1) : $urandom_range(0, 2));
    endtask

    initial begin
        int wait_cycles;
        board = new();
        calm = 1'b0;
        i_rst_n <= 1'b0;
        op_ch.valid <= 1'b0;
        op_ch.kind <= KIND_INSERT;
        op_ch.queue_id <= '0;
        op_ch.thread_id <= '0;
        op_ch.source_queue <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty next, remove of a non-member, extremes, self re-insert,
        // move-all onto itself and onto a non-empty queue
        send_op(KIND_NEXT,     0,  0, 0);
        send_op(KIND_NEXT,     7,  0, 7);
        send_op(KIND_REMOVE,   7, 63, 0);
        send_op(KIND_INSERT,   7, 63, 0);
        send_op(KIND_INSERT,   7,  0, 0);
        send_op(KIND_INSERT,   7,  5, 0);
        send_op(KIND_INSERT,   7, 63, 0);
        send_op(KIND_NEXT,     7,  0, 0);
        send_op(KIND_REMOVE,   0,  5, 0);
        send_op(KIND_REMOVE,   7,  5, 0);
        send_op(KIND_MOVE_ALL, 7,  0, 7);
        send_op(KIND_MOVE_ALL, 3,  0, 0);
        send_op(KIND_INSERT,   0, 42, 5);
        send_op(KIND_MOVE_ALL, 0, 42, 7);
        send_op(KIND_NEXT,     0, 21, 2);
        send_op(KIND_INSERT,   2,  0, 0);
        send_op(KIND_REMOVE,   0, 63, 0);
        send_op(KIND_REMOVE,   0,  0, 0);
        send_op(KIND_NEXT,     7,  0, 0);

        for (int i = 0; i < 600; i++) begin
            if (i == 540) calm = 1'b1;
            random_op();
        end
        op_ch.valid <= 1'b0;

        wait_cycles = 0;
        while (board.pending.size() != 0 && wait_cycles < 100000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (200) @(posedge i_clk);

        $display("ops: %0d insert, %0d remove, %0d next, %0d move-all; %0d results checked",
                 op_count[KIND_INSERT], op_count[KIND_REMOVE], op_count[KIND_NEXT],
                 op_count[KIND_MOVE_ALL], board.checked);
        if (board.mismatches == 0 && board.pending.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches, %0d results missing",
                     board.mismatches, board.pending.size());
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("timeout");
        $display("TEST FAILED");
        $finish;
    end

endmodule
